### hdl/hpq_pkg.sv
// ---------------------------------------------------------------------------
// hpq_pkg
// Shared types, codes and widths of the binary max-heap priority queue.
// ---------------------------------------------------------------------------
package hpq_pkg;

	localparam int unsigned DEPTH_DEF = 128;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 8;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Request operation codes.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Output tdata: count, top_valid, top_value, removed_value, zero fill.
	localparam int PAY_W   = COUNT_W + 1 + 2 * VALUE_W;
	localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		RA_ROOT,
		RA_PARENT,
		RA_LEFT,
		RA_RIGHT,
		RA_LAST
	} raddr_sel_t;

	typedef enum logic [1:0] {
		WD_CUR,
		WD_RDATA,
		WD_MVAL
	} wdata_sel_t;

	typedef enum logic [1:0] {
		IX_HOLD,
		IX_PARENT,
		IX_ZERO,
		IX_MIDX
	} idx_sel_t;

	typedef struct packed {
		logic       load;
		logic       rd_en;
		raddr_sel_t rd_sel;
		logic       wr_en;
		wdata_sel_t wr_sel;
		idx_sel_t   idx_sel;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       set_full;
		logic       set_empty;
		logic       take_removed;
		logic       take_cur;
		logic       take_left;
		logic       take_right;
	} dp_cmd_t;

	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic idx_zero;
		logic up_gt;
		logic dn_leaf;
		logic dn_has_r;
		logic dn_r_wins;
		logic dn_gt;
	} dp_sts_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
		logic                      top_valid;
		logic signed [VALUE_W-1:0] top_value;
		logic signed [VALUE_W-1:0] removed_value;
	} result_t;

endpackage

### hdl/hpq_dp.sv
// ---------------------------------------------------------------------------
// hpq_dp
// Datapath: heap memory, entry count, moving value, hole index, child pick.
// ---------------------------------------------------------------------------
module hpq_dp #(
	parameter int unsigned DEPTH = hpq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [hpq_pkg::CAP_W-1:0]           cfg_wr_data,
	input  logic                                in_cmd,
	input  logic signed [hpq_pkg::VALUE_W-1:0]  in_value,
	input  hpq_pkg::dp_cmd_t                    cmd,
	output hpq_pkg::dp_sts_t                    sts,
	output hpq_pkg::result_t                    result
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = IW + 2;
	localparam int LW = (CW > hpq_pkg::CAP_W) ? CW : hpq_pkg::CAP_W;

	logic signed [hpq_pkg::VALUE_W-1:0] heap_mem_q [DEPTH];
	logic signed [hpq_pkg::VALUE_W-1:0] rdata_q;
	logic signed [hpq_pkg::VALUE_W-1:0] cur_q;
	logic signed [hpq_pkg::VALUE_W-1:0] mval_q;
	logic signed [hpq_pkg::VALUE_W-1:0] removed_q;
	logic [IW-1:0]                      idx_q;
	logic [IW-1:0]                      midx_q;
	logic [CW-1:0]                      count_q;
	logic [hpq_pkg::CAP_W-1:0]          cap_q;
	logic                               op_q;
	logic [hpq_pkg::STATUS_W-1:0]       status_q;

	logic [IW-1:0]                      idx_m1;
	logic [IW-1:0]                      parent;
	logic [CW-1:0]                      cnt_m1;
	logic [KW-1:0]                      left;
	logic [KW-1:0]                      right;
	logic [KW-1:0]                      count_k;
	logic [LW-1:0]                      count_l;
	logic [LW-1:0]                      cap_l;
	logic [IW-1:0]                      raddr;
	logic signed [hpq_pkg::VALUE_W-1:0] wdata;

	assign idx_m1  = idx_q - IW'(1);
	assign parent  = idx_m1 >> 1;
	assign cnt_m1  = count_q - CW'(1);
	assign left    = {1'b0, idx_q, 1'b1};
	assign right   = left + KW'(1);
	assign count_k = KW'(count_q);
	assign count_l = LW'(count_q);
	assign cap_l   = LW'(cap_q);

	always_comb begin
		unique case (cmd.rd_sel)
			hpq_pkg::RA_ROOT:   raddr = '0;
			hpq_pkg::RA_PARENT: raddr = parent;
			hpq_pkg::RA_LEFT:   raddr = left[IW-1:0];
			hpq_pkg::RA_RIGHT:  raddr = right[IW-1:0];
			hpq_pkg::RA_LAST:   raddr = cnt_m1[IW-1:0];
			default:            raddr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			hpq_pkg::WD_CUR:   wdata = cur_q;
			hpq_pkg::WD_RDATA: wdata = rdata_q;
			hpq_pkg::WD_MVAL:  wdata = mval_q;
			default:           wdata = cur_q;
		endcase
	end

	// Single-port heap storage with registered read data.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			heap_mem_q[idx_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= heap_mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cap_q    <= hpq_pkg::CAP_RESET;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= cnt_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_cmd;
			cur_q     <= in_value;
			idx_q     <= count_q[IW-1:0];
			status_q  <= hpq_pkg::ST_DONE;
			removed_q <= '0;
		end else begin
			if (cmd.set_full) begin
				status_q <= hpq_pkg::ST_FULL;
			end
			if (cmd.set_empty) begin
				status_q <= hpq_pkg::ST_EMPTY;
			end
			if (cmd.take_removed) begin
				removed_q <= rdata_q;
			end
			if (cmd.take_cur) begin
				cur_q <= rdata_q;
			end
			unique case (cmd.idx_sel)
				hpq_pkg::IX_HOLD:   idx_q <= idx_q;
				hpq_pkg::IX_PARENT: idx_q <= parent;
				hpq_pkg::IX_ZERO:   idx_q <= '0;
				hpq_pkg::IX_MIDX:   idx_q <= midx_q;
				default:            idx_q <= idx_q;
			endcase
		end
		if (cmd.take_left) begin
			mval_q <= rdata_q;
			midx_q <= left[IW-1:0];
		end else if (cmd.take_right) begin
			mval_q <= rdata_q;
			midx_q <= right[IW-1:0];
		end
	end

	always_comb begin
		sts.is_remove = (op_q == hpq_pkg::CMD_REMOVE);
		sts.full      = (count_l >= cap_l) || (count_q == CW'(DEPTH));
		sts.empty     = (count_q == '0);
		sts.idx_zero  = (idx_q == '0);
		sts.up_gt     = (cur_q > rdata_q);
		sts.dn_leaf   = (left >= count_k);
		sts.dn_has_r  = (right < count_k);
		sts.dn_r_wins = !(mval_q > rdata_q);
		sts.dn_gt     = (mval_q > cur_q);
	end

	always_comb begin
		result.status        = status_q;
		result.count         = count_l[hpq_pkg::COUNT_W-1:0];
		result.top_valid     = (count_q != '0);
		result.top_value     = (count_q != '0) ? rdata_q : '0;
		result.removed_value = removed_q;
	end

endmodule

### hdl/hpq_ctrl.sv
// ---------------------------------------------------------------------------
// hpq_ctrl
// Controller: sequences sift-up and sift-down over the heap datapath.
// ---------------------------------------------------------------------------
module hpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             out_free,
	input  hpq_pkg::dp_sts_t sts,
	output hpq_pkg::dp_cmd_t cmd,
	output logic             out_load,
	output logic             in_ready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_UP_CHK,
		S_UP_CMP,
		S_RM_LAST,
		S_RM_CUR,
		S_DN_CHK,
		S_DN_LEFT,
		S_DN_RSEL,
		S_DN_CMP,
		S_FIN,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   ready_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_remove) begin
					if (sts.empty) begin
						cmd.set_empty = 1'b1;
						state_d       = S_FIN;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = hpq_pkg::RA_ROOT;
						state_d    = S_RM_LAST;
					end
				end else if (sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_UP_CHK;
				end
			end
			S_UP_CHK: begin
				if (sts.idx_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = hpq_pkg::WD_CUR;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = hpq_pkg::RA_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.up_gt) begin
					cmd.wr_sel  = hpq_pkg::WD_RDATA;
					cmd.idx_sel = hpq_pkg::IX_PARENT;
					state_d     = S_UP_CHK;
				end else begin
					cmd.wr_sel = hpq_pkg::WD_CUR;
					state_d    = S_FIN;
				end
			end
			S_RM_LAST: begin
				cmd.take_removed = 1'b1;
				cmd.cnt_dec      = 1'b1;
				cmd.rd_en        = 1'b1;
				cmd.rd_sel       = hpq_pkg::RA_LAST;
				cmd.idx_sel      = hpq_pkg::IX_ZERO;
				state_d          = S_RM_CUR;
			end
			S_RM_CUR: begin
				cmd.take_cur = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (sts.dn_leaf) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = hpq_pkg::WD_CUR;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = hpq_pkg::RA_LEFT;
					state_d    = S_DN_LEFT;
				end
			end
			S_DN_LEFT: begin
				cmd.take_left = 1'b1;
				if (sts.dn_has_r) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = hpq_pkg::RA_RIGHT;
					state_d    = S_DN_RSEL;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_RSEL: begin
				cmd.take_right = sts.dn_r_wins;
				state_d        = S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.dn_gt) begin
					cmd.wr_sel  = hpq_pkg::WD_MVAL;
					cmd.idx_sel = hpq_pkg::IX_MIDX;
					state_d     = S_DN_CHK;
				end else begin
					cmd.wr_sel = hpq_pkg::WD_CUR;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = hpq_pkg::RA_ROOT;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assign in_ready = ready_q;

endmodule

### hdl/max_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values with insert and remove-max requests.
// ---------------------------------------------------------------------------
// Each request on the slave side is either an insert (tuser 0) of the signed
// value in tdata or a remove of the current maximum (tuser 1), and produces
// exactly one result on the master side carrying the status in tuser and the
// entry count, a top-valid flag, the current maximum and the removed value in
// tdata. The block handles one request at a time. The heap sits in a single
// port memory with registered read data, so each level of a sift-up costs
// one read and one write, and each level of a sift-down up to two reads and
// one write. The finished result waits in an output register, and the block
// keeps accepting the next request while it waits; that request completes
// once the register frees up. Inserts are dropped with a full status once the
// count reaches the capacity limit (capped at DEPTH); a remove on an empty
// heap reports an empty status and changes nothing. The capacity limit is
// written through cfg_wr_en and cfg_wr_data, which the user must do only
// while the block is idle; the block itself does not enforce this. The limit
// resets to 128. No clearing pass is needed after reset, since an entry at
// or above the count is read only at a count of zero, and its value is then
// masked from the result.
// ---------------------------------------------------------------------------
module max_heap_priority_queue #(
	parameter int unsigned DEPTH = hpq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Capacity limit register write.
	input  logic                          cfg_wr_en,
	input  logic [hpq_pkg::CAP_W-1:0]     cfg_wr_data,
	// Request channel.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hpq_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
	input  logic                          s_tuser,   // [0] cmd
	// Result channel.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] count, [8] top_valid, [40:9] top_value, [72:41] removed_value,
	// [79:73] zero
	output logic [hpq_pkg::TDATA_W-1:0]   m_tdata,
	output logic [hpq_pkg::STATUS_W-1:0]  m_tuser    // [1:0] status
);

	hpq_pkg::dp_cmd_t dp_cmd;
	hpq_pkg::dp_sts_t dp_sts;
	hpq_pkg::result_t result;

	logic accept;
	logic out_free;
	logic out_load;

	logic                         m_valid_q;
	logic [hpq_pkg::TDATA_W-1:0]  m_data_q;
	logic [hpq_pkg::STATUS_W-1:0] m_user_q;

	// A request is taken when both sides of the slave handshake agree.
	assign accept = s_tvalid & s_tready;

	// The output register can take a new result when it is empty or its
	// current result leaves in this cycle.
	assign out_free = !m_valid_q || m_tready;

	hpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_free (out_free),
		.sts      (dp_sts),
		.cmd      (dp_cmd),
		.out_load (out_load),
		.in_ready (s_tready)
	);

	hpq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_cmd      (s_tuser),
		.in_value    (s_tdata),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.result      (result)
	);

	// Output register: valid is control state, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_user_q <= result.status;
			m_data_q <= hpq_pkg::TDATA_W'({result.removed_value, result.top_value,
				result.top_valid, result.count});
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

### bench/max_heap_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Self-checking bench for the binary max-heap priority queue.
// ---------------------------------------------------------------------------
// A behavioral copy of the heap runs beside the block. Every request that the
// block accepts is applied to that copy, and the outcome is queued. Each
// result that the block hands over is compared field by field with the oldest
// queued outcome. A short directed table covers the empty and full cases, the
// value extremes, ties, a capacity limit of zero, a limit lowered below the
// fill level and a limit above the depth. Random phases under several capacity
// settings follow, the first saturating the limit at the depth, with random
// stalls on both sides, a long receiver hold-off and a full drain mid-phase.
// ---------------------------------------------------------------------------
module max_heap_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_DEPTH = hpq_pkg::DEPTH_DEF;
	// Idle cycles waited after the last result, so the block is surely at rest.
	localparam int SETTLE = 48;
	// Length of the receiver hold-off that backs the block up.
	localparam int HOLD_LEN = 300;
	// The longest correct quiet stretch is the hold-off plus one request, and
	// a drain plus a register write is far shorter. Allow many times that.
	localparam int QUIET_LIMIT = 4000;
	localparam int IDLE_PCT = 13;
	localparam int MAX_PRINTS = 40;

	typedef enum logic [1:0] {
		ROW_CAP,
		ROW_REQ,
		ROW_TYPED
	} row_kind_t;

	// One row of the directed table. ROW_TYPED rows carry a hand-written outcome.
	typedef struct {
		row_kind_t                   kind;
		logic                        cmd;
		logic [hpq_pkg::VALUE_W-1:0] value;
		logic [hpq_pkg::CAP_W-1:0]   cap;
		hpq_pkg::result_t            want;
	} plan_row_t;

	// One random phase: capacity (negative means random), share of inserts in
	// percent, number of requests, and whether both sides run without idling.
	typedef struct {
		int cap;
		int insert_pct;
		int items;
		bit steady;
	} phase_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [hpq_pkg::CAP_W-1:0]    cfg_wr_data;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [hpq_pkg::VALUE_W-1:0]  s_tdata;   // [31:0] value
	logic                         s_tuser;   // [0] cmd
	logic                         m_tvalid;
	logic                         m_tready;
	// [7:0] count, [8] top_valid, [40:9] top_value, [72:41] removed_value,
	// [79:73] zero
	logic [hpq_pkg::TDATA_W-1:0]  m_tdata;
	logic [hpq_pkg::STATUS_W-1:0] m_tuser;   // [1:0] status

	// Shared controls, written with nonblocking assignments so that every
	// process sees the same value within a time step.
	logic no_idle;
	int   holds_asked;

	// Behavioral copy of the heap and of the capacity register.
	logic signed [hpq_pkg::VALUE_W-1:0] heap_copy [HEAP_DEPTH];
	int                                 held = 0;
	logic [hpq_pkg::CAP_W-1:0]          cap_copy = hpq_pkg::CAP_RESET;

	// Outcomes still owed by the block, oldest first.
	hpq_pkg::result_t awaited[$];
	plan_row_t        test_plan[$];

	int mismatch_cnt = 0;
	int n_checked = 0;
	int n_insert = 0;
	int n_remove = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_cap_writes = 0;
	int peak_fill = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	max_heap_priority_queue DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// Applies one request to the heap copy and returns the result it causes.
	// An insert climbs while strictly greater than its parent. A remove moves
	// the last entry to the root and sinks it toward the larger child, taking
	// the right child on a tie, while that child is strictly greater.
	function automatic hpq_pkg::result_t heap_outcome(input logic cmd,
			input logic signed [hpq_pkg::VALUE_W-1:0] val);
		hpq_pkg::result_t                   r;
		int                                 lim;
		int                                 i;
		int                                 up;
		int                                 lc;
		int                                 rc;
		int                                 pick;
		logic signed [hpq_pkg::VALUE_W-1:0] t;
		r = '0;
		lim = (cap_copy > HEAP_DEPTH) ? HEAP_DEPTH : int'(cap_copy);
		if (cmd == hpq_pkg::CMD_INSERT) begin
			if (held >= lim) begin
				r.status = hpq_pkg::ST_FULL;
			end else begin
				i = held;
				heap_copy[i] = val;
				held++;
				while (i != 0) begin
					up = (i - 1) / 2;
					if (!(heap_copy[i] > heap_copy[up]))
						break;
					t = heap_copy[i];
					heap_copy[i] = heap_copy[up];
					heap_copy[up] = t;
					i = up;
				end
				r.status = hpq_pkg::ST_DONE;
			end
		end else begin
			if (held == 0) begin
				r.status = hpq_pkg::ST_EMPTY;
			end else begin
				r.removed_value = heap_copy[0];
				held--;
				heap_copy[0] = heap_copy[held];
				i = 0;
				forever begin
					lc = 2 * i + 1;
					rc = lc + 1;
					if (lc >= held)
						break;
					if (rc >= held)
						pick = lc;
					else
						pick = (heap_copy[lc] > heap_copy[rc]) ? lc : rc;
					if (!(heap_copy[pick] > heap_copy[i]))
						break;
					t = heap_copy[i];
					heap_copy[i] = heap_copy[pick];
					heap_copy[pick] = t;
					i = pick;
				end
				r.status = hpq_pkg::ST_DONE;
			end
		end
		r.count = hpq_pkg::COUNT_W'(held);
		r.top_valid = (held != 0);
		r.top_value = (held != 0) ? heap_copy[0] : '0;
		return r;
	endfunction

	function automatic void plan_req(input logic cmd,
			input logic [hpq_pkg::VALUE_W-1:0] val);
		plan_row_t row;
		row = '{kind: ROW_REQ, cmd: cmd, value: val, cap: '0, want: '0};
		test_plan.push_back(row);
	endfunction

	function automatic void plan_typed(input logic cmd,
			input logic [hpq_pkg::VALUE_W-1:0] val,
			input logic [hpq_pkg::STATUS_W-1:0] st, input int cnt,
			input logic [hpq_pkg::VALUE_W-1:0] top,
			input logic [hpq_pkg::VALUE_W-1:0] rem);
		plan_row_t row;
		row = '{kind: ROW_TYPED, cmd: cmd, value: val, cap: '0, want: '0};
		row.want.status = st;
		row.want.count = hpq_pkg::COUNT_W'(cnt);
		row.want.top_valid = (cnt != 0);
		row.want.top_value = top;
		row.want.removed_value = rem;
		test_plan.push_back(row);
	endfunction

	function automatic void plan_cap(input logic [hpq_pkg::CAP_W-1:0] v);
		plan_row_t row;
		row = '{kind: ROW_CAP, cmd: hpq_pkg::CMD_INSERT, value: '0, cap: v, want: '0};
		test_plan.push_back(row);
	endfunction

	// Mostly full-range values, with a share of small values to force ties and
	// a share of the signed extremes, zero and all ones.
	function automatic logic [hpq_pkg::VALUE_W-1:0] pick_value();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 6)
			return $urandom;
		if (mode < 8)
			return hpq_pkg::VALUE_W'(int'($urandom_range(0, 8)) - 4);
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS)
			$display("%0t: result %0d, %s differs: got %0h, expected %0h",
				$time, n_checked, what, got, want);
	endtask

	// Offers one request, possibly after random idle cycles, and holds it
	// until accepted. On acceptance the heap copy takes the request and the
	// outcome is queued; a directed row may supply the outcome by hand.
	task automatic send_request(input logic cmd,
			input logic [hpq_pkg::VALUE_W-1:0] val,
			input bit typed, input hpq_pkg::result_t typed_want);
		hpq_pkg::result_t r;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= val;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = heap_outcome(cmd, val);
		awaited.push_back(typed ? typed_want : r);
		if (cmd == hpq_pkg::CMD_INSERT)
			n_insert++;
		else
			n_remove++;
		if (r.status == hpq_pkg::ST_FULL)
			n_full++;
		if (r.status == hpq_pkg::ST_EMPTY)
			n_empty++;
		if (held > peak_fill)
			peak_fill = held;
	endtask

	// Stops offering, waits for every owed result, then lets the block settle.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes the capacity limit; only called once the block is at rest.
	task automatic write_capacity(input logic [hpq_pkg::CAP_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cap_copy = v;
		n_cap_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: random stalls, plus a long hold-off each time the stimulus
	// asks for one. The hold-off is counted here, not in the sender.
	initial begin : result_sink
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_served != holds_asked) begin
				holds_served++;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Compares each handed-over result with the oldest owed outcome. Values
	// are read at the edge itself, before the block updates anything.
	always @(posedge clk) begin : result_check
		hpq_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (awaited.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[63:0], '0);
			end else begin
				want = awaited.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", m_tuser, want.status);
				if (m_tdata[0 +: hpq_pkg::COUNT_W] !== want.count)
					report_mismatch("count", m_tdata[0 +: hpq_pkg::COUNT_W], want.count);
				if (m_tdata[hpq_pkg::COUNT_W] !== want.top_valid)
					report_mismatch("top_valid", m_tdata[hpq_pkg::COUNT_W],
						want.top_valid);
				if (m_tdata[hpq_pkg::COUNT_W + 1 +: hpq_pkg::VALUE_W] !== want.top_value)
					report_mismatch("top_value",
						m_tdata[hpq_pkg::COUNT_W + 1 +: hpq_pkg::VALUE_W],
						want.top_value);
				if (m_tdata[hpq_pkg::COUNT_W + 1 + hpq_pkg::VALUE_W +: hpq_pkg::VALUE_W]
						!== want.removed_value)
					report_mismatch("removed_value",
						m_tdata[hpq_pkg::COUNT_W + 1 + hpq_pkg::VALUE_W +: hpq_pkg::VALUE_W],
						want.removed_value);
			end
		end
	end

	// Ends the run if neither side moves a request for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("max_heap_priority_queue verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		phase_t                    phases [9];
		logic [hpq_pkg::CAP_W-1:0] new_cap;
		logic                      cmd;
		int                        k;

		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= hpq_pkg::CMD_INSERT;
		no_idle <= 1'b0;
		holds_asked <= 0;

		// Directed table. The heap starts empty with the limit at its reset
		// value of 128.
		plan_typed(hpq_pkg::CMD_REMOVE, 32'h0000_0000, hpq_pkg::ST_EMPTY, 0,
			32'h0, 32'h0);
		plan_typed(hpq_pkg::CMD_INSERT, 32'h7fff_ffff, hpq_pkg::ST_DONE, 1,
			32'h7fff_ffff, 32'h0);
		plan_typed(hpq_pkg::CMD_INSERT, 32'h8000_0000, hpq_pkg::ST_DONE, 2,
			32'h7fff_ffff, 32'h0);
		plan_req(hpq_pkg::CMD_INSERT, 32'h0000_0000);
		plan_req(hpq_pkg::CMD_INSERT, 32'hffff_ffff);
		// Equal to the root, so it must not climb past it.
		plan_req(hpq_pkg::CMD_INSERT, 32'h7fff_ffff);
		// Equal siblings exercise the right-child rule on the way down.
		plan_req(hpq_pkg::CMD_INSERT, 32'h0000_0005);
		plan_req(hpq_pkg::CMD_INSERT, 32'h0000_0005);
		plan_req(hpq_pkg::CMD_INSERT, 32'haaaa_aaaa);
		// The value of a remove is ignored, so it is never zero here.
		plan_typed(hpq_pkg::CMD_REMOVE, 32'hdead_beef, hpq_pkg::ST_DONE, 7,
			32'h7fff_ffff, 32'h7fff_ffff);
		// Limit lowered below the fill level: entries stay, inserts drop.
		plan_cap(8'd2);
		plan_typed(hpq_pkg::CMD_INSERT, 32'h0000_0001, hpq_pkg::ST_FULL, 7,
			32'h7fff_ffff, 32'h0);
		repeat (6) plan_req(hpq_pkg::CMD_REMOVE, 32'hffff_ffff);
		plan_typed(hpq_pkg::CMD_REMOVE, 32'h0000_0000, hpq_pkg::ST_DONE, 0,
			32'h0, 32'h8000_0000);
		plan_typed(hpq_pkg::CMD_REMOVE, 32'h0000_0000, hpq_pkg::ST_EMPTY, 0,
			32'h0, 32'h0);
		// A limit of zero drops every insert.
		plan_cap(8'd0);
		plan_typed(hpq_pkg::CMD_INSERT, 32'h0000_0007, hpq_pkg::ST_FULL, 0,
			32'h0, 32'h0);
		plan_cap(8'd1);
		plan_typed(hpq_pkg::CMD_INSERT, 32'h1234_5678, hpq_pkg::ST_DONE, 1,
			32'h1234_5678, 32'h0);
		plan_typed(hpq_pkg::CMD_INSERT, 32'h0000_0001, hpq_pkg::ST_FULL, 1,
			32'h1234_5678, 32'h0);
		plan_typed(hpq_pkg::CMD_REMOVE, 32'h0000_0000, hpq_pkg::ST_DONE, 0,
			32'h0, 32'h1234_5678);
		plan_cap(8'd255);
		plan_req(hpq_pkg::CMD_INSERT, 32'h0000_0003);
		plan_req(hpq_pkg::CMD_INSERT, 32'h0000_0003);

		// Random phases. The first fills the heap past 128 under a limit of 255
		// to hit the saturation at the depth; later ones drain it, lower the
		// limit below the fill level, fill it to exactly 128, drop everything
		// under a zero limit and finally empty it again.
		phases = '{
			'{cap: 255, insert_pct: 75, items: 400, steady: 1'b0},
			'{cap: 128, insert_pct: 35, items: 250, steady: 1'b0},
			'{cap: 7,   insert_pct: 60, items: 150, steady: 1'b0},
			'{cap: 128, insert_pct: 50, items: 300, steady: 1'b1},
			'{cap: -1,  insert_pct: 55, items: 200, steady: 1'b0},
			'{cap: 1,   insert_pct: 50, items: 100, steady: 1'b0},
			'{cap: 128, insert_pct: 80, items: 300, steady: 1'b0},
			'{cap: 0,   insert_pct: 50, items: 100, steady: 1'b0},
			'{cap: 128, insert_pct: 20, items: 200, steady: 1'b0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (test_plan[i]) begin
			if (test_plan[i].kind == ROW_CAP) begin
				drain_pipeline();
				write_capacity(test_plan[i].cap);
			end else begin
				send_request(test_plan[i].cmd, test_plan[i].value,
					test_plan[i].kind == ROW_TYPED, test_plan[i].want);
			end
		end

		foreach (phases[p]) begin
			drain_pipeline();
			if (phases[p].cap < 0)
				new_cap = hpq_pkg::CAP_W'($urandom_range(0, 255));
			else
				new_cap = hpq_pkg::CAP_W'(phases[p].cap);
			write_capacity(new_cap);
			no_idle <= phases[p].steady;
			for (k = 0; k < phases[p].items; k++) begin
				// While the heap fills, the receiver stops for a long stretch
				// and the sender keeps offering until the block pushes back.
				if (p == 0 && k == 200)
					holds_asked <= holds_asked + 1;
				// Midway through the steady phase the sender waits for every
				// owed result before going on.
				if (p == 3 && k == 150)
					drain_pipeline();
				cmd = ($urandom_range(0, 99) < phases[p].insert_pct)
					? hpq_pkg::CMD_INSERT : hpq_pkg::CMD_REMOVE;
				send_request(cmd, pick_value(), 1'b0, '0);
			end
		end

		no_idle <= 1'b0;
		drain_pipeline();
		if (awaited.size() != 0)
			report_mismatch("results never delivered", awaited.size(), 0);

		$display("Run covered %0d inserts and %0d removes under %0d limit settings,"
			, n_insert, n_remove, n_cap_writes);
		$display("with %0d dropped inserts, %0d empty removes, peak fill %0d, %0d results.",
			n_full, n_empty, peak_fill, n_checked);
		if (mismatch_cnt == 0)
			$display("max_heap_priority_queue verification clean");
		else
			$display("max_heap_priority_queue verification failed");
		$finish;
	end

endmodule
